// ===== hw/rtl/ilp_pkg.sv =====
// IPv6 literal parser package: character codes, parse phases, parser state type,
// and the hex-digit and group-close helpers.
// No dependencies; used by every module of the parser.
package ilp_pkg;

  localparam int CHAR_W  = 8;
  localparam int WORD_W  = 16;
  localparam int ADDR_W  = 64;
  localparam int GROUPS  = 8;

  localparam logic [3:0] GROUP_LIMIT = 4'd8;
  localparam logic [2:0] DIGIT_LIMIT = 3'd4;

  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

  typedef enum logic [5:0] {
    PH_FIRST       = 6'b000001,
    PH_CONTENT     = 6'b000010,
    PH_LEAD_COLON  = 6'b000100,
    PH_GROUP_START = 6'b001000,
    PH_DIGITS      = 6'b010000,
    PH_ONE_COLON   = 6'b100000
  } phase_t;

  typedef logic [GROUPS-1:0][WORD_W-1:0] group_arr_t;

  // head: groups before "::" at their final index.
  // tail: groups after "::", newest in entry 0 (maps to group 7).
  typedef struct packed {
    phase_t            phase;
    group_arr_t        head;
    group_arr_t        tail;
    logic [3:0]        count;
    logic              cseen;
    logic [WORD_W-1:0] partial;
    logic [2:0]        dcount;
    logic              bracketed;
    logic              bad;
  } parse_state_t;

  function automatic parse_state_t state_init();
    parse_state_t s;
    s = '0;
    s.phase = PH_FIRST;
    return s;
  endfunction

  // {valid, value}
  function automatic logic [4:0] nibble_of(logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] d;
    logic [4:0]        r;
    r = '0;
    priority if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d = ch - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d = ch - 8'h37;
      r = {1'b1, d[3:0]};
    end else begin
      d = '0;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

  function automatic parse_state_t close_group(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.cseen) begin
      r.tail = {s.tail[GROUPS-2:0], s.partial};
    end else begin
      r.head[s.count[2:0]] = s.partial;
    end
    r.count   = s.count + 4'd1;
    r.partial = '0;
    r.dcount  = '0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/ipv6_literal_parser_core.sv =====
// IPv6 address literal parser, top level: input register, parser state, result register.
// Depends on ilp_pkg, ilp_step and ilp_finish.
//
// Takes one ASCII character per request (s_tlast on the final one) and returns one
// result per literal: the 128-bit address and a malformed flag in m_tuser (address
// zero when set). Brackets around the literal are optional. One character is taken
// every cycle while no final character waits on a stalled result; the final character
// passes through the input register and then the result register, which raises m_tvalid.
// A stalled result holds back the next final character and the input behind it; earlier
// characters keep flowing into the parser state.
module ipv6_literal_parser_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ilp_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] char_in
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*ilp_pkg::ADDR_W-1:0]      m_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic                              m_tuser    // [0] status
);
  import ilp_pkg::*;

  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  parse_state_t      state;
  parse_state_t      state_next;
  parse_state_t      fin_state;
  logic              advance;
  logic              ok;
  logic [ADDR_W-1:0] addr_high;
  logic [ADDR_W-1:0] addr_low;

  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  ilp_step u_step (
    .state      (state),
    .ch         (in_char),
    .last       (in_last),
    .state_next (state_next),
    .fin_state  (fin_state)
  );

  ilp_finish u_finish (
    .fin_state (fin_state),
    .ok        (ok),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      state    <= state_init();
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (advance) state <= state_next;
      if (advance && in_last) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
    if (advance && in_last) begin
      m_tdata <= {addr_low, addr_high};
      m_tuser <= !ok;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("malformed result carries a nonzero address");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> state.phase == PH_FIRST && state.count == 4'd0)
    else $error("parser not rearmed after final character");

  a_count: assert property (@(posedge clk) disable iff (rst)
    state.count <= GROUP_LIMIT && state.dcount <= DIGIT_LIMIT)
    else $error("group or digit count out of range");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    !state.cseen |-> state.tail == '0)
    else $error("tail groups stored before compression");

endmodule

// ===== hw/rtl/ilp_step.sv =====
// Per-character grammar step of the IPv6 literal parser.
// Depends on ilp_pkg; gives the next parser state and the state to finish from.
module ilp_step (
  input  ilp_pkg::parse_state_t           state,
  input  logic [ilp_pkg::CHAR_W-1:0]      ch,
  input  logic                            last,
  output ilp_pkg::parse_state_t           state_next,
  output ilp_pkg::parse_state_t           fin_state
);
  import ilp_pkg::*;

  function automatic parse_state_t open_group(parse_state_t s, logic [3:0] nib);
    parse_state_t r;
    r = s;
    if (s.count >= GROUP_LIMIT) begin
      r.bad = 1'b1;
    end else begin
      r.partial = {{(WORD_W-4){1'b0}}, nib};
      r.dcount  = 3'd1;
      r.phase   = PH_DIGITS;
    end
    return r;
  endfunction

  function automatic parse_state_t mark_compress(parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.cseen) begin
      r.bad = 1'b1;
    end else begin
      r.cseen = 1'b1;
      r.phase = PH_GROUP_START;
    end
    return r;
  endfunction

  logic         first;
  logic         first_br;
  logic         colon;
  logic [4:0]   nib;
  parse_state_t eff;
  parse_state_t fed;

  assign first    = (state.phase == PH_FIRST);
  assign first_br = first && (ch == CH_LBRACK);
  assign colon    = (ch == CH_COLON);
  assign nib      = nibble_of(ch);

  always_comb begin
    eff = state;
    if (first) begin
      eff.phase     = PH_CONTENT;
      eff.bracketed = first_br;
    end
  end

  always_comb begin
    fed = eff;
    if (!eff.bad) begin
      unique case (eff.phase)
        PH_CONTENT: begin
          if (colon) fed.phase = PH_LEAD_COLON;
          else if (nib[4]) fed = open_group(eff, nib[3:0]);
          else fed.bad = 1'b1;
        end
        PH_LEAD_COLON: begin
          if (colon) fed = mark_compress(eff);
          else fed.bad = 1'b1;
        end
        PH_GROUP_START: begin
          if (nib[4]) fed = open_group(eff, nib[3:0]);
          else fed.bad = 1'b1;
        end
        PH_DIGITS: begin
          if (nib[4]) begin
            if (eff.dcount >= DIGIT_LIMIT) begin
              fed.bad = 1'b1;
            end else begin
              fed.partial = {eff.partial[WORD_W-5:0], nib[3:0]};
              fed.dcount  = eff.dcount + 3'd1;
            end
          end else if (colon) begin
            fed       = close_group(eff);
            fed.phase = PH_ONE_COLON;
          end else begin
            fed.bad = 1'b1;
          end
        end
        PH_ONE_COLON: begin
          if (colon) fed = mark_compress(eff);
          else if (nib[4]) fed = open_group(eff, nib[3:0]);
          else fed.bad = 1'b1;
        end
        default: fed.bad = 1'b1;
      endcase
    end
  end

  always_comb begin
    fin_state = fed;
    if (first_br) begin
      fin_state     = eff;
      fin_state.bad = 1'b1;
    end else if (eff.bracketed) begin
      // closing bracket ends the address; it is not fed
      fin_state     = eff;
      fin_state.bad = eff.bad || (ch != CH_RBRACK);
    end
  end

  assign state_next = last ? state_init() : (first_br ? eff : fed);

endmodule

// ===== hw/rtl/ilp_finish.sv =====
// End-of-literal check and address assembly of the IPv6 literal parser.
// Depends on ilp_pkg; head and tail group stores are merged by OR.
module ilp_finish (
  input  ilp_pkg::parse_state_t           fin_state,
  output logic                            ok,
  output logic [ilp_pkg::ADDR_W-1:0]      addr_high,
  output logic [ilp_pkg::ADDR_W-1:0]      addr_low
);
  import ilp_pkg::*;

  parse_state_t             s;
  logic                     shape_ok;
  logic                     count_ok;
  logic [WORD_W-1:0]        words [GROUPS];

  always_comb begin
    s = fin_state;
    if (fin_state.phase == PH_DIGITS) s = close_group(fin_state);
  end

  assign shape_ok = (fin_state.phase == PH_DIGITS) || (fin_state.phase == PH_GROUP_START);
  assign count_ok = s.cseen ? (s.count < GROUP_LIMIT) : (s.count == GROUP_LIMIT);
  assign ok       = !fin_state.bad && shape_ok && count_ok;

  always_comb begin
    addr_high = '0;
    addr_low  = '0;
    for (int i = 0; i < GROUPS; i++) begin
      words[i] = s.head[i] | s.tail[GROUPS-1-i];
    end
    for (int i = 0; i < GROUPS/2; i++) begin
      addr_high[ADDR_W-1-WORD_W*i -: WORD_W] = words[i];
      addr_low[ADDR_W-1-WORD_W*i -: WORD_W]  = words[i+GROUPS/2];
    end
    if (!ok) begin
      addr_high = '0;
      addr_low  = '0;
    end
  end

endmodule
